// ===== rtl/bmsm_pkg.sv =====
// Shared types and constants for the Boyer-Moore stream matcher.
package bmsm_pkg;

  // Depth of the queue between the front and the back
  localparam int QUEUE_DEPTH = 2;

  // Classified operation of one input beat
  typedef enum logic [1:0] {
    OP_PATTERN      = 2'd0,
    OP_PATTERN_LAST = 2'd1,
    OP_TEXT         = 2'd2
  } op_t;

  // One queued beat
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } item_t;

endpackage

// ===== rtl/bmsm_front.sv =====
// Front end: takes input beats, classifies them and queues them for the back end.
module bmsm_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            kind,
  input  logic [7:0]      data_byte,
  input  logic            pattern_end,
  output logic            q_valid,
  output bmsm_pkg::item_t q_item,
  input  logic            q_pop
);
  import bmsm_pkg::*;

  item_t      slots [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      item_in;
  logic       push;

  // Classify: the end mark only counts on a pattern byte
  always_comb begin
    item_in.data = data_byte;
    if (kind) begin
      item_in.op = OP_TEXT;
    end else if (pattern_end) begin
      item_in.op = OP_PATTERN_LAST;
    end else begin
      item_in.op = OP_PATTERN;
    end
  end

  assign in_stall = (count == 2'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (!push && q_pop) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/bmsm_back.sv =====
// Back end: pattern store, table build sequencer, text window and right-to-left compare.
module bmsm_back #(
  parameter int PATTERN_MAX   = 32,
  parameter int ALPHABET_SIZE = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  bmsm_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [31:0]     match_start
);
  import bmsm_pkg::*;

  localparam int PW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int SW = LW + 2;
  localparam logic [PW-1:0] LAST_SLOT = PW'(PATTERN_MAX - 1);
  localparam logic [LW-1:0] MAX_LEN   = LW'(PATTERN_MAX);
  localparam logic [AW-1:0] LAST_SYM  = AW'(ALPHABET_SIZE - 1);

  typedef enum logic [18:0] {
    ST_IDLE  = 19'h00001,
    ST_BFILL = 19'h00002,
    ST_BRD   = 19'h00004,
    ST_BWR   = 19'h00008,
    ST_STOP  = 19'h00010,
    ST_SRD   = 19'h00020,
    ST_SCHK  = 19'h00040,
    ST_GINIT = 19'h00080,
    ST_G2RD  = 19'h00100,
    ST_G2CHK = 19'h00200,
    ST_G2WR  = 19'h00400,
    ST_G3RD  = 19'h00800,
    ST_G3WR  = 19'h01000,
    ST_FIN   = 19'h02000,
    ST_CRD   = 19'h04000,
    ST_CCHK  = 19'h08000,
    ST_XSH   = 19'h10000,
    ST_MEMIT = 19'h20000,
    ST_SPARE = 19'h40000
  } state_t;

  // Reduce a byte modulo the alphabet size by restoring subtraction
  function automatic logic [AW-1:0] alpha_fold(input logic [7:0] b);
    logic [15:0] r;
    r = {8'd0, b};
    for (int s = 7; s >= 0; s--) begin
      if (r >= (16'(ALPHABET_SIZE) << s)) begin
        r = r - (16'(ALPHABET_SIZE) << s);
      end
    end
    return AW'(r);
  endfunction

  // Memories
  logic [7:0]    pattern_store     [PATTERN_MAX];
  logic [7:0]    text_window       [PATTERN_MAX];
  logic [LW-1:0] bad_char_shift    [ALPHABET_SIZE];
  logic [LW-1:0] good_suffix_shift [PATTERN_MAX];
  logic [LW-1:0] suffix_lengths    [PATTERN_MAX];

  // Registers
  state_t        state;
  logic [LW-1:0] pattern_length;
  logic          pattern_ready;
  logic [31:0]   text_position;
  logic [31:0]   alignment_start;
  logic [PW-1:0] ring;
  logic [PW-1:0] rptr;
  logic [PW-1:0] i;
  logic [LW-1:0] k;
  logic [LW-1:0] j;
  logic [AW-1:0] sym;

  // Registered read data
  logic [7:0]    pa_q;
  logic [7:0]    pb_q;
  logic [7:0]    w_q;
  logic [LW-1:0] bad_q;
  logic [LW-1:0] gs_q;
  logic [LW-1:0] suff_q;

  // Ports and helpers
  logic          take;
  logic [LW-1:0] len_eff;
  logic [LW-1:0] len_new;
  logic [LW-1:0] m1i;
  logic [PW-1:0] m_last;
  logic          eq;
  logic          k_lt_i;
  logic          g2_hit;
  logic [PW-1:0] pa_ra;
  logic [PW-1:0] pb_ra;
  logic          p_we;
  logic          w_we;
  logic          bad_we;
  logic [AW-1:0] bad_wa;
  logic [LW-1:0] bad_wd;
  logic          suff_we;
  logic [PW-1:0] suff_wa;
  logic [LW-1:0] suff_wd;
  logic          gs_we;
  logic [PW-1:0] gs_wa;
  logic [LW-1:0] gs_wd;
  logic signed [SW-1:0] bc;
  logic signed [SW-1:0] gs_s;
  logic signed [SW-1:0] shift;

  // Common terms
  assign take    = (state == ST_IDLE) && q_valid;
  assign q_pop   = take;
  assign len_eff = pattern_ready ? '0 : pattern_length;
  assign p_we    = take && (q_item.op != OP_TEXT) && (len_eff < MAX_LEN);
  assign len_new = p_we ? len_eff + LW'(1) : len_eff;
  assign w_we    = take && (q_item.op == OP_TEXT) && pattern_ready;
  assign m_last  = PW'(pattern_length - LW'(1));
  assign m1i     = pattern_length - LW'(1) - LW'(i);
  assign eq      = (pa_q == pb_q);
  assign k_lt_i  = (k < LW'(i));
  assign g2_hit  = (suff_q == LW'(i) + LW'(1)) && (j < m1i);
  assign pa_ra   = (state == ST_SRD) ? PW'(LW'(i) - k) : i;
  assign pb_ra   = PW'(pattern_length - LW'(1) - k);

  // Table write ports
  always_comb begin
    bad_we  = (state == ST_BFILL) || (state == ST_BWR);
    bad_wa  = (state == ST_BFILL) ? sym : alpha_fold(pa_q);
    bad_wd  = (state == ST_BFILL) ? pattern_length : m1i;
    suff_we = (state == ST_STOP) || ((state == ST_SCHK) && !(eq && k_lt_i));
    suff_wa = (state == ST_STOP) ? m_last : i;
    suff_wd = (state == ST_STOP) ? pattern_length : (eq ? k + LW'(1) : k);
    gs_we   = (state == ST_GINIT) || (state == ST_G2WR) || (state == ST_G3WR);
    gs_wa   = (state == ST_G3WR) ? PW'(pattern_length - LW'(1) - suff_q) : PW'(j);
    gs_wd   = (state == ST_GINIT) ? pattern_length : m1i;
  end

  // Mismatch shift: larger of bad-character and good-suffix rules
  always_comb begin
    bc    = SW'(bad_q) - SW'(pattern_length) + SW'(1) + SW'(i);
    gs_s  = SW'(gs_q);
    shift = (bc > gs_s) ? bc : gs_s;
  end

  // Pattern store, two read ports
  always_ff @(posedge clk) begin
    if (p_we) begin
      pattern_store[PW'(len_eff)] <= q_item.data;
    end
    pa_q <= pattern_store[pa_ra];
    pb_q <= pattern_store[pb_ra];
  end

  // Text window ring
  always_ff @(posedge clk) begin
    if (w_we) begin
      text_window[ring] <= q_item.data;
    end
    w_q <= text_window[rptr];
  end

  // Bad-character table
  always_ff @(posedge clk) begin
    if (bad_we) begin
      bad_char_shift[bad_wa] <= bad_wd;
    end
    bad_q <= bad_char_shift[alpha_fold(w_q)];
  end

  // Suffix lengths
  always_ff @(posedge clk) begin
    if (suff_we) begin
      suffix_lengths[suff_wa] <= suff_wd;
    end
    suff_q <= suffix_lengths[i];
  end

  // Good-suffix table
  always_ff @(posedge clk) begin
    if (gs_we) begin
      good_suffix_shift[gs_wa] <= gs_wd;
    end
    gs_q <= good_suffix_shift[i];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      pattern_length  <= '0;
      pattern_ready   <= 1'b0;
      text_position   <= '0;
      alignment_start <= '0;
      ring            <= '0;
      out_valid       <= 1'b0;
    end else begin
      // the match step drives the result register itself
      if (out_valid && !out_stall && state != ST_MEMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_item.op != OP_TEXT) begin
              pattern_ready  <= 1'b0;
              pattern_length <= len_new;
              if (q_item.op == OP_PATTERN_LAST) begin
                sym   <= '0;
                state <= ST_BFILL;
              end
            end else if (pattern_ready) begin
              ring          <= (ring == LAST_SLOT) ? '0 : ring + PW'(1);
              text_position <= text_position + 32'd1;
              if (text_position - alignment_start == 32'(pattern_length) - 32'd1) begin
                i     <= m_last;
                rptr  <= ring;
                state <= ST_CRD;
              end
            end
          end
        end
        // bad-character table: fill with m, then walk the pattern
        ST_BFILL: begin
          sym <= sym + AW'(1);
          if (sym == LAST_SYM) begin
            i     <= '0;
            state <= (pattern_length > LW'(1)) ? ST_BRD : ST_STOP;
          end
        end
        ST_BRD: state <= ST_BWR;
        ST_BWR: begin
          if (LW'(i) == pattern_length - LW'(2)) begin
            state <= ST_STOP;
          end else begin
            i     <= i + PW'(1);
            state <= ST_BRD;
          end
        end
        // suffix lengths, right to left
        ST_STOP: begin
          j <= '0;
          if (pattern_length == LW'(1)) begin
            state <= ST_GINIT;
          end else begin
            i     <= PW'(pattern_length - LW'(2));
            k     <= '0;
            state <= ST_SRD;
          end
        end
        ST_SRD: state <= ST_SCHK;
        ST_SCHK: begin
          if (eq && k_lt_i) begin
            k     <= k + LW'(1);
            state <= ST_SRD;
          end else if (i == '0) begin
            j     <= '0;
            state <= ST_GINIT;
          end else begin
            i     <= i - PW'(1);
            k     <= '0;
            state <= ST_SRD;
          end
        end
        // good-suffix: preset, prefix pass, then suffix pass
        ST_GINIT: begin
          if (j == pattern_length - LW'(1)) begin
            i     <= m_last;
            j     <= '0;
            state <= ST_G2RD;
          end else begin
            j <= j + LW'(1);
          end
        end
        ST_G2RD: state <= ST_G2CHK;
        ST_G2CHK: begin
          if (g2_hit) begin
            state <= ST_G2WR;
          end else if (i == '0) begin
            state <= (pattern_length > LW'(1)) ? ST_G3RD : ST_FIN;
          end else begin
            i     <= i - PW'(1);
            state <= ST_G2RD;
          end
        end
        ST_G2WR: begin
          j <= j + LW'(1);
          if (j + LW'(1) < m1i) begin
            state <= ST_G2WR;
          end else if (i == '0) begin
            state <= (pattern_length > LW'(1)) ? ST_G3RD : ST_FIN;
          end else begin
            i     <= i - PW'(1);
            state <= ST_G2RD;
          end
        end
        ST_G3RD: state <= ST_G3WR;
        ST_G3WR: begin
          if (LW'(i) == pattern_length - LW'(2)) begin
            state <= ST_FIN;
          end else begin
            i     <= i + PW'(1);
            state <= ST_G3RD;
          end
        end
        ST_FIN: begin
          pattern_ready   <= 1'b1;
          text_position   <= '0;
          alignment_start <= '0;
          ring            <= '0;
          state           <= ST_IDLE;
        end
        // right-to-left compare: each byte takes a read step (ST_CRD) and a check step (ST_CCHK)
        ST_CRD: state <= ST_CCHK;
        ST_CCHK: begin
          if (pa_q == w_q) begin
            if (i == '0) begin
              state <= ST_MEMIT;
            end else begin
              i     <= i - PW'(1);
              rptr  <= (rptr == '0) ? LAST_SLOT : rptr - PW'(1);
              state <= ST_CRD;
            end
          end else begin
            state <= ST_XSH;
          end
        end
        ST_XSH: begin
          alignment_start <= alignment_start + 32'(shift);
          state           <= ST_IDLE;
        end
        ST_MEMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            match_start     <= alignment_start;
            alignment_start <= alignment_start + 32'(gs_q);
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    pattern_length <= MAX_LEN)
    else $error("pattern length beyond store depth");

  a_cmp_needs_pattern: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CRD) |-> (pattern_ready && pattern_length != '0))
    else $error("compare started without a built pattern");

  a_build_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |=> (pattern_ready && text_position == '0 && alignment_start == '0))
    else $error("build did not leave a clean text position");

  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_MEMIT))
    else $error("result raised outside the match step");
`endif

endmodule

// ===== rtl/boyer_moore_stream_matcher_top.sv =====
// A pattern byte is taken in the idle state; the last one also runs the table build for
//   pattern length m: symbol fill, bad-character walk, suffix lengths, good-suffix passes.
// A text byte is taken in the idle state; one that completes an alignment adds a compare
//   byte by byte (one shared comparator, registered memory reads), then a shift or emit.
// Throughput: one beat at a time in the back end, a two-beat queue in front of it.
// Reset clears control, length, offsets and the ready flag; tables hold nothing until built.
module boyer_moore_stream_matcher_top #(
  parameter int PATTERN_MAX   = 32,
  parameter int ALPHABET_SIZE = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  input  logic        pattern_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] match_start
);
  import bmsm_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // Front: accept and classify
  bmsm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .data_byte   (data_byte),
    .pattern_end (pattern_end),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  // Back: build tables and match
  bmsm_back #(
    .PATTERN_MAX   (PATTERN_MAX),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .match_start (match_start)
  );

endmodule

// ===== verif/boyer_moore_stream_matcher_checker.sv =====
// Checker for the Boyer-Moore stream matcher: predicts match offsets and compares results.
module boyer_moore_stream_matcher_checker #(
  parameter int PATTERN_MAX   = 32,
  parameter int ALPHABET_SIZE = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  input  logic        pattern_end,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] match_start,
  output int          mismatches,
  output int          offsets_pending
);

  // Predictor state
  logic [7:0]  pat_bytes [PATTERN_MAX];
  int          pat_len;
  int          skip_by_char [ALPHABET_SIZE];
  int          skip_by_suffix [PATTERN_MAX];
  int          suffix_len [PATTERN_MAX];
  logic [7:0]  window [PATTERN_MAX];
  logic [31:0] text_pos;
  logic [31:0] align_pos;
  bit          armed;
  int          wr_slot;
  logic [31:0] expected_offsets [$];

  // Longest common suffix ending at each pattern position
  function automatic void build_suffix_len(int m);
    int f;
    int g;
    int mirror;
    f = 0;
    g = m - 1;
    suffix_len[m-1] = m;
    for (int i = m - 2; i >= 0; i--) begin
      mirror = i + m - 1 - f;
      if (i > g && suffix_len[mirror] < i - g) begin
        suffix_len[i] = suffix_len[mirror];
      end else begin
        if (i < g) g = i;
        f = i;
        while (g >= 0 && pat_bytes[g] == pat_bytes[g+m-1-f]) g--;
        suffix_len[i] = f - g;
      end
    end
  endfunction

  // Bad-character and good-suffix shift tables
  function automatic void build_shift_tables();
    int m;
    int j;
    m = pat_len;
    j = 0;
    for (int i = 0; i < ALPHABET_SIZE; i++) skip_by_char[i] = m;
    for (int i = 0; i < m - 1; i++) skip_by_char[pat_bytes[i] % ALPHABET_SIZE] = m - 1 - i;
    build_suffix_len(m);
    for (int i = 0; i < m; i++) skip_by_suffix[i] = m;
    for (int i = m - 1; i >= 0; i--) begin
      if (suffix_len[i] == i + 1) begin
        for (; j < m - 1 - i; j++)
          if (skip_by_suffix[j] == m) skip_by_suffix[j] = m - 1 - i;
      end
    end
    for (int i = 0; i <= m - 2; i++) skip_by_suffix[m-1-suffix_len[i]] = m - 1 - i;
  endfunction

  // One accepted beat: update state, queue an offset on a full match
  function automatic void take_beat(logic k, logic [7:0] b, logic e);
    logic [31:0] newest;
    int slot;
    int m;
    int i;
    int idx;
    int bc;
    int gs;
    if (!k) begin
      if (armed) begin
        armed = 0;
        pat_len = 0;
      end
      if (pat_len < PATTERN_MAX) begin
        pat_bytes[pat_len] = b;
        pat_len++;
      end
      if (e && pat_len > 0) begin
        build_shift_tables();
        armed = 1;
        text_pos = '0;
        align_pos = '0;
        wr_slot = 0;
      end
      return;
    end
    if (!armed) return;
    newest = text_pos;
    slot = wr_slot;
    m = pat_len;
    window[slot] = b;
    wr_slot = (wr_slot + 1) % PATTERN_MAX;
    text_pos = text_pos + 1;
    if (newest - align_pos != 32'(m - 1)) return;
    // compare right to left
    for (i = m - 1; i >= 0; i--) begin
      idx = (slot + PATTERN_MAX - (m - 1 - i)) % PATTERN_MAX;
      if (pat_bytes[i] != window[idx]) break;
    end
    if (i < 0) begin
      expected_offsets = {expected_offsets, align_pos};
      align_pos = align_pos + 32'(skip_by_suffix[0]);
    end else begin
      idx = (slot + PATTERN_MAX - (m - 1 - i)) % PATTERN_MAX;
      bc = skip_by_char[window[idx] % ALPHABET_SIZE] - m + 1 + i;
      gs = skip_by_suffix[i];
      align_pos = align_pos + 32'(bc > gs ? bc : gs);
    end
  endfunction

  // Result beats first, then the input beat of the same edge
  always @(posedge clk) begin
    if (rst) begin
      pat_len = 0;
      text_pos = '0;
      align_pos = '0;
      armed = 0;
      wr_slot = 0;
      expected_offsets.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_offsets.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected match_start %0d, nothing expected", match_start);
        end else if (expected_offsets[0] !== match_start) begin
          mismatches++;
          if (mismatches <= 10)
            $display("match_start mismatch: expected %0d, got %0d",
                     expected_offsets[0], match_start);
          void'(expected_offsets.pop_front());
        end else begin
          void'(expected_offsets.pop_front());
        end
      end
      if (in_valid && !in_stall) take_beat(kind, data_byte, pattern_end);
    end
    offsets_pending = expected_offsets.size();
  end

endmodule

// ===== verif/boyer_moore_stream_matcher_top_test.sv =====
// Stimulus and verdict for the Boyer-Moore stream matcher testbench.
module boyer_moore_stream_matcher_top_test;
  import bmsm_pkg::*;

  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  DRAIN_WAIT  = 3000;
  localparam int  LONG_HOLD   = 400;
  localparam bit  KIND_PATTERN = 1'b0;
  localparam bit  KIND_TEXT    = 1'b1;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        kind;
  logic [7:0]  data_byte;
  logic        pattern_end;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] match_start;
  int          mismatches;
  int          offsets_pending;
  int          beats_sent;
  int          cycles;
  bit          no_idle;
  bit          hold_request;

  boyer_moore_stream_matcher_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .data_byte(data_byte), .pattern_end(pattern_end), .out_valid(out_valid),
    .out_stall(out_stall), .match_start(match_start)
  );

  boyer_moore_stream_matcher_checker chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .data_byte(data_byte), .pattern_end(pattern_end), .out_valid(out_valid),
    .out_stall(out_stall), .match_start(match_start), .mismatches(mismatches),
    .offsets_pending(offsets_pending)
  );

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("boyer_moore_stream_matcher_top test failed");
      $finish;
    end
  end

  // Send one beat after a random gap (none in no_idle mode), hold it until taken
  task automatic send_beat(logic k, logic [7:0] b, logic e);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    kind = k;
    data_byte = b;
    pattern_end = e;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    beats_sent++;
  endtask

  // Result side: random stall per beat (none in no_idle mode), one long hold-off on request
  initial begin
    int n;
    out_stall = 1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        out_stall = 1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 0;
      end
      n = no_idle ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
        out_stall = 1;
        repeat (n) @(negedge clk);
      end
      out_stall = 0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    logic [7:0] pat [40];
    logic [7:0] alph [3];
    int plen;
    int tlen;
    int r;
    bit held;
    rst = 1;
    in_valid = 0;
    kind = 0;
    data_byte = 0;
    pattern_end = 0;
    beats_sent = 0;
    no_idle = 0;
    hold_request = 0;
    held = 0;
    repeat (8) @(negedge clk);
    rst = 0;

    // Directed: text before any pattern is ignored
    send_beat(KIND_TEXT, 8'h00, 1'b1);
    send_beat(KIND_TEXT, 8'hFF, 1'b0);
    // extreme bytes, end mark on a text byte ignored
    send_beat(KIND_PATTERN, 8'h00, 1'b0);
    send_beat(KIND_PATTERN, 8'hFF, 1'b1);
    send_beat(KIND_TEXT, 8'h00, 1'b0);
    send_beat(KIND_TEXT, 8'hFF, 1'b1);
    send_beat(KIND_TEXT, 8'h00, 1'b0);
    send_beat(KIND_TEXT, 8'hFF, 1'b0);
    // single-byte pattern replaces the old one
    send_beat(KIND_PATTERN, 8'hAA, 1'b1);
    send_beat(KIND_TEXT, 8'hAA, 1'b0);
    send_beat(KIND_TEXT, 8'hAA, 1'b0);
    send_beat(KIND_TEXT, 8'h55, 1'b0);
    // repeated prefix exercises the good-suffix rule
    send_beat(KIND_PATTERN, 8'h61, 1'b0);
    send_beat(KIND_PATTERN, 8'h61, 1'b0);
    send_beat(KIND_PATTERN, 8'h62, 1'b1);
    send_beat(KIND_TEXT, 8'h61, 1'b0);
    send_beat(KIND_TEXT, 8'h61, 1'b0);
    send_beat(KIND_TEXT, 8'h61, 1'b0);
    send_beat(KIND_TEXT, 8'h62, 1'b0);
    send_beat(KIND_TEXT, 8'h61, 1'b0);
    send_beat(KIND_TEXT, 8'h62, 1'b0);

    // Random: pattern then text over a small alphabet, with planted copies
    while (beats_sent < 1000) begin
      no_idle = ($urandom_range(0, 4) == 0);
      foreach (alph[a]) alph[a] = 8'($urandom);
      r = $urandom_range(0, 9);
      plen = (r < 8) ? $urandom_range(1, 6) : (r == 8) ? $urandom_range(7, 32)
                                                       : $urandom_range(33, 36);
      for (int p = 0; p < plen; p++) begin
        pat[p] = ($urandom_range(0, 15) == 0) ? 8'($urandom) : alph[$urandom_range(0, 2)];
        // occasionally no end mark: following text is ignored until a build
        send_beat(KIND_PATTERN, pat[p],
                  (p == plen - 1) && ($urandom_range(0, 19) != 0));
      end
      if (!held && beats_sent > 300) begin
        hold_request = 1;
        held = 1;
      end
      tlen = $urandom_range(20, 60);
      for (int t = 0; t < tlen && beats_sent < 1000; t++) begin
        if ($urandom_range(0, 7) == 0) begin
          for (int p = 0; p < plen && p < 32; p++)
            send_beat(KIND_TEXT, pat[p], 1'($urandom_range(0, 1)));
        end else if ($urandom_range(0, 19) == 0) begin
          send_beat(KIND_TEXT, 8'($urandom), 1'($urandom_range(0, 1)));
        end else begin
          send_beat(KIND_TEXT, alph[$urandom_range(0, 2)], 1'($urandom_range(0, 1)));
        end
      end
    end
    in_valid = 0;
    no_idle = 0;

    // Drain, then allow for a trailing table build
    while (offsets_pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatches == 0 && offsets_pending == 0) begin
      $display("boyer_moore_stream_matcher_top test passed");
    end else begin
      $display("boyer_moore_stream_matcher_top test failed");
    end
    $finish;
  end

endmodule
